@@ rtl/updec_pkg.sv @@
package updec_pkg;

	localparam int CountWidth = 16;
	localparam int QDepth     = 4;
	localparam int QPtrWidth  = $clog2(QDepth);

	typedef logic [CountWidth-1:0] count_t;

	// Configuration register indexes.
	localparam logic CfgFormMode = 1'b0;
	localparam logic CfgOutLimit = 1'b1;

	localparam logic [7:0] ChPercent = 8'h25;
	localparam logic [7:0] ChPlus    = 8'h2B;
	localparam logic [7:0] ChSpace   = 8'h20;

	typedef enum logic [1:0] {
		LvlNone,
		LvlPct,
		LvlDigit
	} level_t;

	// One classified input transaction: up to three decoded bytes, already truncated.
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      n;
		logic            last;
		count_t          base;
	} entry_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
	endfunction

	// Valid only for hex digits; letters of either case have bit 6 set.
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		return c[6] ? (c[3:0] + 4'd9) : c[3:0];
	endfunction

endpackage

@@ rtl/updec_in_if.sv @@
interface updec_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

@@ rtl/updec_out_if.sv @@
interface updec_out_if import updec_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       run_last;
	logic       string_end;
	count_t     out_count;

	modport source (output valid, output out_byte, output byte_valid, output run_last,
		output string_end, output out_count, input ready);
	modport sink (input valid, input out_byte, input byte_valid, input run_last,
		input string_end, input out_count, output ready);
endinterface

@@ rtl/updec_front.sv @@
module updec_front import updec_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       form_mode,
	input  count_t     out_limit,
	updec_in_if.sink   src,
	input  logic       q_full,
	output logic       push,
	output entry_t     push_entry
);

	level_t          lvl_q, lvl_d;
	logic [7:0]      held_q, held_d;
	count_t          count_q, count_d;
	logic            accept;
	logic            done;
	logic            hex_b;
	logic [1:0]      nraw, nsent;
	logic [2:0][7:0] cand;
	logic [7:0]      plain_b;
	count_t          room;

	assign src.ready = !q_full;
	assign accept    = src.valid && src.ready;
	assign hex_b     = is_hex(src.in_byte);
	assign plain_b   = (form_mode && src.in_byte == ChPlus) ? ChSpace : src.in_byte;

	always_comb begin
		lvl_d  = LvlNone;
		held_d = held_q;
		done   = 1'b0;
		nraw   = 2'd0;
		cand   = '0;
		case (lvl_q)
			LvlDigit: begin
				if (hex_b) begin
					cand[0] = {hex_val(held_q), hex_val(src.in_byte)};
					nraw    = 2'd1;
					done    = 1'b1;
				end else begin
					cand[0] = ChPercent;
					cand[1] = held_q;
					nraw    = 2'd2;
				end
			end
			LvlPct: begin
				if (hex_b && !src.in_last) begin
					held_d = src.in_byte;
					lvl_d  = LvlDigit;
					done   = 1'b1;
				end else begin
					cand[0] = ChPercent;
					nraw    = 2'd1;
				end
			end
			default: ;
		endcase
		if (!done) begin
			if (src.in_byte == ChPercent && !src.in_last) begin
				lvl_d = LvlPct;
			end else begin
				case (nraw)
					2'd0: cand[0] = plain_b;
					2'd1: cand[1] = plain_b;
					default: cand[2] = plain_b;
				endcase
				nraw = nraw + 2'd1;
			end
		end

		// Bytes beyond the limit are dropped; the earliest ones go out first.
		room = (count_q >= out_limit) ? '0 : (out_limit - count_q);
		if (room < count_t'(nraw))
			nsent = room[1:0];
		else
			nsent = nraw;
		count_d = count_q + count_t'(nsent);

		if (src.in_last) begin
			lvl_d   = LvlNone;
			held_d  = '0;
			count_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q   <= LvlNone;
			held_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			lvl_q   <= lvl_d;
			held_q  <= held_d;
			count_q <= count_d;
		end
	end

	assign push             = accept && (nsent != 2'd0 || src.in_last);
	assign push_entry.bytes = cand;
	assign push_entry.n     = nsent;
	assign push_entry.last  = src.in_last;
	assign push_entry.base  = count_q;

endmodule

@@ rtl/updec_queue.sv @@
module updec_queue import updec_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output entry_t head,
	output logic   empty,
	output logic   full
);

	entry_t               mem_q [QDepth];
	logic [QPtrWidth-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPtrWidth:0]   fill_q;

	assign empty = (fill_q == '0);
	assign full  = (fill_q == (QPtrWidth+1)'(QDepth));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				fill_q <= fill_q + 1'b1;
			else if (pop && !push)
				fill_q <= fill_q - 1'b1;
		end
	end

endmodule

@@ rtl/updec_back.sv @@
module updec_back import updec_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  entry_t      head,
	input  logic        empty,
	output logic        pop,
	updec_out_if.source dst
);

	logic [1:0] k_q;
	logic [1:0] last_idx;
	logic       fin;
	logic       load;
	logic       has_byte;

	logic       valid_q;
	logic [7:0] byte_q;
	logic       byte_valid_q;
	logic       run_last_q;
	logic       string_end_q;
	count_t     count_q;

	assign has_byte = (head.n != 2'd0);
	assign last_idx = has_byte ? (head.n - 2'd1) : 2'd0;
	assign fin      = (k_q == last_idx);
	assign load     = !empty && (!valid_q || dst.ready);
	assign pop      = load && fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			k_q     <= '0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (dst.ready)
				valid_q <= 1'b0;
			if (load)
				k_q <= fin ? 2'd0 : (k_q + 2'd1);
		end
	end

	// An entry with no bytes is the empty final result of a string.
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q       <= has_byte ? head.bytes[k_q] : 8'd0;
			byte_valid_q <= has_byte;
			run_last_q   <= fin;
			string_end_q <= head.last && fin;
			count_q      <= head.base + count_t'(k_q) + count_t'(has_byte);
		end
	end

	assign dst.valid      = valid_q;
	assign dst.out_byte   = byte_q;
	assign dst.byte_valid = byte_valid_q;
	assign dst.run_last   = run_last_q;
	assign dst.string_end = string_end_q;
	assign dst.out_count  = count_q;

`ifndef SYNTHESIS
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && has_byte) |-> (k_q < head.n)) else $error("byte index past entry");

	a_empty_result_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !byte_valid_q) |-> (run_last_q && string_end_q))
		else $error("result without byte that does not end the string");
`endif

endmodule

@@ rtl/url_percent_decode_top.sv @@
// URL percent decoder. Takes one encoded byte per transaction on src and returns decoded
// bytes on dst, one result per transaction; one input can cause up to three results
// (a held '%' and digit flushed before a plain byte). The front end classifies and accepts
// one input per cycle while its four-entry queue has room; the back end drains the queue
// at one result per cycle while dst is ready. Results are registered in the queue and then,
// one at a time, in the back end's output register. The final input of a string (in_last)
// always ends with a result that has string_end set and carries the decoded length in
// out_count; if nothing was decoded by it, that result has byte_valid low. Decoded bytes
// beyond out_limit are dropped silently. Configuration: index 0 is form_mode ('+' decodes
// to space), index 1 is out_limit.
module url_percent_decode_top import updec_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	updec_in_if.sink    src,
	updec_out_if.source dst
);

	logic   form_mode_q;
	count_t out_limit_q;
	logic   push, pop, empty, full;
	entry_t push_entry, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			form_mode_q <= 1'b0;
			out_limit_q <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgFormMode: form_mode_q <= cfg_data[0];
				CfgOutLimit: out_limit_q <= cfg_data[CountWidth-1:0];
				default: ;
			endcase
		end
	end

	updec_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.form_mode  (form_mode_q),
		.out_limit  (out_limit_q),
		.src        (src),
		.q_full     (full),
		.push       (push),
		.push_entry (push_entry)
	);

	updec_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (empty),
		.full       (full)
	);

	updec_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.dst    (dst)
	);

endmodule
